>>> hw/rtl/gbd_pkg.sv
package gbd_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int KSIZE         = 5;
    localparam int NGROUPS       = 6;
    localparam int LINES         = 4;
    localparam int NCHAN         = 3;
    localparam int SAMPLE_W      = 8;
    localparam int PIXEL_W       = NCHAN * SAMPLE_W;
    localparam int ROW_W         = 16;
    localparam int WEIGHT_W      = 16;
    localparam int FRAC_BITS     = 16;
    localparam int GSUM_W        = 11;   // up to eight samples of one distance
    localparam int PROD_W        = GSUM_W + WEIGHT_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 3;
    localparam int IMG_WIDTH_W   = 11;
    localparam int GROUP_W       = 3;

    localparam int RESET_WIDTH   = 640;
    localparam logic [WEIGHT_W-1:0] RESET_W_CENTER = 16'd2674;
    localparam logic [WEIGHT_W-1:0] RESET_W_D1     = 16'd2661;
    localparam logic [WEIGHT_W-1:0] RESET_W_D2     = 16'd2648;
    localparam logic [WEIGHT_W-1:0] RESET_W_D4     = 16'd2621;
    localparam logic [WEIGHT_W-1:0] RESET_W_D5     = 16'd2608;
    localparam logic [WEIGHT_W-1:0] RESET_W_D8     = 16'd2570;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_DECIMATE,
        REG_W_CENTER,
        REG_W_D1,
        REG_W_D2,
        REG_W_D4,
        REG_W_D5,
        REG_W_D8
    } cfg_reg_t;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIXEL_W-1:0] window_t;
    typedef logic [NGROUPS-1:0][WEIGHT_W-1:0] weights_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             src_new;
        logic             end_flag;
        logic             load_held;
        logic [KSIZE-1:0] row_mask;
        logic [KSIZE-1:0] col_mask;
    } tap_ctrl_t;

    // Weight group of window tap (k, m): offset di = 2-k, dj = 2-m.
    function automatic logic [GROUP_W-1:0] tap_group(input int k, input int m);
        int di;
        int dj;
        int d2;
        logic [GROUP_W-1:0] g;
        di = 2 - k;
        dj = 2 - m;
        d2 = di * di + dj * dj;
        case (d2)
            0:       g = 3'd0;
            1:       g = 3'd1;
            2:       g = 3'd2;
            4:       g = 3'd3;
            5:       g = 3'd4;
            default: g = 3'd5;
        endcase
        return g;
    endfunction

endpackage

>>> hw/rtl/gaussian_blur_5x5_decimate_top.sv
// 5x5 Gaussian pyramid level for an RGB raster stream. The block takes one
// pixel request per clock and gives at most one result request per clock; the
// input stalls only in a cycle in which the output register holds a result
// request that the receiver stalls, and then the whole pipeline holds. A
// result stands 2*W+2 input items behind the pixel it belongs to (W is the
// frame width latched on the first pixel of a frame), and in decimate mode
// each kept result is held until the next one is known so that the last of
// the frame carries frame_end. After a frame send 2*W+2 flush items to drain
// it. Inside, an item passes five registers from acceptance to the output
// register: input and line-store read, window shift, masked group sums,
// weight products, result. The four previous rows live in one memory of
// MAX_WIDTH words, each word holding the four rows of one column, read and
// rewritten once per item; it needs no clearing pass, since taps outside the
// frame are masked to zero. Write configuration only while the block is idle.
module gaussian_blur_5x5_decimate_top #(
    parameter int MAX_WIDTH = gbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [gbd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gbd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [gbd_pkg::SAMPLE_W-1:0]       red_in,
    input  logic [gbd_pkg::SAMPLE_W-1:0]       green_in,
    input  logic [gbd_pkg::SAMPLE_W-1:0]       blue_in,
    input  logic                               flush,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [gbd_pkg::SAMPLE_W-1:0]       red_out,
    output logic [gbd_pkg::SAMPLE_W-1:0]       green_out,
    output logic [gbd_pkg::SAMPLE_W-1:0]       blue_out,
    output logic                               frame_end
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);      // frame width
    localparam int CW  = $clog2(MAX_WIDTH);          // column, line-store address
    localparam int DRW = $clog2(2 * MAX_WIDTH + 3);  // drain count
    localparam int PW  = gbd_pkg::PIXEL_W;
    localparam int SW  = gbd_pkg::SAMPLE_W;
    localparam int LSW = gbd_pkg::LINES * PW;
    localparam int RW  = gbd_pkg::ROW_W;
    localparam int RESET_FW = (gbd_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                  : gbd_pkg::RESET_WIDTH;

    // configuration registers
    logic [gbd_pkg::IMG_WIDTH_W-1:0] cfg_width_reg;
    logic                            cfg_dec_reg;
    gbd_pkg::weights_t               weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= gbd_pkg::IMG_WIDTH_W'(gbd_pkg::RESET_WIDTH);
            cfg_dec_reg    <= 1'b0;
            weights_reg[0] <= gbd_pkg::RESET_W_CENTER;
            weights_reg[1] <= gbd_pkg::RESET_W_D1;
            weights_reg[2] <= gbd_pkg::RESET_W_D2;
            weights_reg[3] <= gbd_pkg::RESET_W_D4;
            weights_reg[4] <= gbd_pkg::RESET_W_D5;
            weights_reg[5] <= gbd_pkg::RESET_W_D8;
        end
        else if (cfg_write_en)
        begin
            unique case (gbd_pkg::cfg_reg_t'(cfg_index))
                gbd_pkg::REG_IMAGE_WIDTH: cfg_width_reg  <= cfg_data[gbd_pkg::IMG_WIDTH_W-1:0];
                gbd_pkg::REG_DECIMATE:    cfg_dec_reg    <= cfg_data[0];
                gbd_pkg::REG_W_CENTER:    weights_reg[0] <= cfg_data;
                gbd_pkg::REG_W_D1:        weights_reg[1] <= cfg_data;
                gbd_pkg::REG_W_D2:        weights_reg[2] <= cfg_data;
                gbd_pkg::REG_W_D4:        weights_reg[3] <= cfg_data;
                gbd_pkg::REG_W_D5:        weights_reg[4] <= cfg_data;
                gbd_pkg::REG_W_D8:        weights_reg[5] <= cfg_data;
            endcase
        end
    end

    // clamp the programmed width into 1..MAX_WIDTH
    logic [WW-1:0] w_cfg;
    always_comb
    begin
        if (cfg_width_reg == '0)
        begin
            w_cfg = WW'(1);
        end
        else if (int'(cfg_width_reg) > MAX_WIDTH)
        begin
            w_cfg = WW'(MAX_WIDTH);
        end
        else
        begin
            w_cfg = WW'(cfg_width_reg);
        end
    end

    // the whole pipeline steps together whenever the output register can move
    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    logic accept;
    assign accept = in_valid && adv;

    // frame position state
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [DRW-1:0] drain_reg, drain_next;
    logic [CW-1:0]  pc_reg, pc_next;       // column of the pixel being filtered
    logic [RW-1:0]  pr_reg, pr_next;       // row of the pixel being filtered
    logic [CW-1:0]  last_c_reg, last_c_next;
    logic [RW-1:0]  last_r_reg, last_r_next;
    logic [WW-1:0]  fw_reg, fw_next;
    logic           fdec_reg, fdec_next;
    logic           held_v_reg, held_v_next;

    logic                ignore;
    logic [CW-1:0]       c_e;
    gbd_pkg::tap_ctrl_t  ctrl_new;

    always_comb
    begin
        logic           fresh;
        logic           restart;
        logic [RW-1:0]  r_e;
        logic [DRW-1:0] d_e;
        logic [CW-1:0]  pc_e;
        logic [RW-1:0]  pr_e;
        logic           held_e;
        logic           ge;
        logic           has_below;
        logic           is_last;
        logic           dec_q;
        logic           held_after;
        logic [WW:0]    pc_x;
        logic [DRW-1:0] delay;

        fresh   = (row_reg == '0) && (col_reg == '0);
        ignore  = flush && (drain_reg == '0) && fresh;
        restart = !flush && ((drain_reg != '0) || fresh);

        // a pixel at frame start, or during drain, opens a new frame
        r_e       = restart ? '0 : row_reg;
        c_e       = restart ? '0 : col_reg;
        d_e       = restart ? '0 : drain_reg;
        pc_e      = restart ? '0 : pc_reg;
        pr_e      = restart ? '0 : pr_reg;
        held_e    = restart ? 1'b0 : held_v_reg;
        fw_next   = restart ? w_cfg : fw_reg;
        fdec_next = restart ? cfg_dec_reg : fdec_reg;

        ctrl_new       = '0;
        ctrl_new.valid = accept && !ignore;

        // flush the held result of an interrupted drain
        if (restart && (drain_reg != '0) && held_v_reg)
        begin
            ctrl_new.emit     = 1'b1;
            ctrl_new.end_flag = 1'b1;
        end

        // the window centre exists once 2*W+2 items are in
        ge = (r_e >= RW'(4)) || ((r_e == RW'(3)) && (fw_next != WW'(1))) ||
             ((r_e == RW'(2)) && (c_e >= CW'(2)));

        pc_x = (WW+1)'(pc_e);
        ctrl_new.row_mask = {pr_e >= RW'(2), pr_e >= RW'(1), 3'b111};
        ctrl_new.col_mask = {pc_e >= CW'(2), pc_e >= CW'(1), 1'b1,
                             (pc_x + (WW+1)'(1)) < (WW+1)'(fw_next),
                             (pc_x + (WW+1)'(2)) < (WW+1)'(fw_next)};

        has_below = flush ? (last_r_reg > pr_e) : (r_e > pr_e);
        is_last   = flush && (pr_e == last_r_reg) && (pc_e == last_c_reg);

        dec_q = ge && fdec_next && !pr_e[0] && !pc_e[0] &&
                ((pc_x + (WW+1)'(1)) < (WW+1)'(fw_next)) && has_below;

        if (dec_q)
        begin
            if (held_e && !ctrl_new.emit)
            begin
                ctrl_new.emit = 1'b1;
            end
            ctrl_new.load_held = 1'b1;
        end
        held_after = dec_q || held_e;

        if (ge && !fdec_next && !ctrl_new.emit)
        begin
            ctrl_new.emit     = 1'b1;
            ctrl_new.src_new  = 1'b1;
            ctrl_new.end_flag = is_last;
        end

        // advance the position
        if ((WW'(c_e) + WW'(1)) >= fw_next)
        begin
            col_next = '0;
            row_next = r_e + RW'(1);
        end
        else
        begin
            col_next = c_e + CW'(1);
            row_next = r_e;
        end

        if (ge)
        begin
            if ((WW'(pc_e) + WW'(1)) >= fw_next)
            begin
                pc_next = '0;
                pr_next = pr_e + RW'(1);
            end
            else
            begin
                pc_next = pc_e + CW'(1);
                pr_next = pr_e;
            end
        end
        else
        begin
            pc_next = '0;
            pr_next = '0;
        end

        last_c_next = flush ? last_c_reg : c_e;
        last_r_next = flush ? last_r_reg : r_e;

        delay       = DRW'({fw_next, 1'b0}) + DRW'(2);
        drain_next  = flush ? (d_e + DRW'(1)) : d_e;
        held_v_next = held_after;

        // drain complete: close the frame
        if (flush && (drain_next >= delay))
        begin
            if (held_after && !ctrl_new.emit)
            begin
                ctrl_new.emit     = 1'b1;
                ctrl_new.end_flag = 1'b1;
                ctrl_new.src_new  = dec_q;
            end
            held_v_next = 1'b0;
            row_next    = '0;
            col_next    = '0;
            drain_next  = '0;
            pc_next     = '0;
            pr_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
            pc_reg     <= '0;
            pr_reg     <= '0;
            last_c_reg <= '0;
            last_r_reg <= '0;
            fw_reg     <= WW'(RESET_FW);
            fdec_reg   <= 1'b0;
            held_v_reg <= 1'b0;
        end
        else if (accept && !ignore)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            pc_reg     <= pc_next;
            pr_reg     <= pr_next;
            last_c_reg <= last_c_next;
            last_r_reg <= last_r_next;
            fw_reg     <= fw_next;
            fdec_reg   <= fdec_next;
            held_v_reg <= held_v_next;
        end
    end

    // input register, aligned with the line-store read
    gbd_pkg::tap_ctrl_t a_ctrl_reg, w_ctrl_reg, c_ctrl_reg, d_ctrl_reg;
    logic [PW-1:0]      a_sample_reg;
    logic [CW-1:0]      a_col_reg;
    logic [LSW-1:0]     ls_rd;
    logic [LSW-1:0]     ls_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctrl_reg <= '0;
            w_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
            d_ctrl_reg <= '0;
        end
        else if (adv)
        begin
            a_ctrl_reg <= ctrl_new;
            w_ctrl_reg <= a_ctrl_reg;
            c_ctrl_reg <= w_ctrl_reg;
            d_ctrl_reg <= c_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // drain positions enter as zero
            a_sample_reg <= flush ? '0 : {blue_in, green_in, red_in};
            a_col_reg    <= c_e;
        end
    end

    // push the current sample on top of the column, drop the oldest row
    assign ls_wr_data = {ls_rd[3*PW-1:0], a_sample_reg};

    gbd_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (LSW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (adv && a_ctrl_reg.valid),
        .wr_addr (a_col_reg),
        .wr_data (ls_wr_data),
        .rd_en   (adv),
        .rd_addr (c_e),
        .rd_data (ls_rd)
    );

    // 5x5 window: row k holds samples k lines back, column m holds m items back
    gbd_pkg::window_t window_reg;

    always_ff @(posedge clk)
    begin
        if (adv && a_ctrl_reg.valid)
        begin
            for (int k = 0; k < gbd_pkg::KSIZE; k++)
            begin
                for (int m = gbd_pkg::KSIZE - 1; m > 0; m--)
                begin
                    window_reg[k][m] <= window_reg[k][m-1];
                end
            end
            window_reg[0][0] <= a_sample_reg;
            for (int k = 1; k < gbd_pkg::KSIZE; k++)
            begin
                window_reg[k][0] <= ls_rd[(k-1)*PW +: PW];
            end
        end
    end

    logic [PW-1:0] pixel;

    gbd_filter u_filter (
        .clk      (clk),
        .adv      (adv),
        .window   (window_reg),
        .row_mask (w_ctrl_reg.row_mask),
        .col_mask (w_ctrl_reg.col_mask),
        .weights  (weights_reg),
        .pixel    (pixel)
    );

    // held result for decimate mode, and the output register
    logic [PW-1:0] held_reg;
    logic [PW-1:0] out_pix_reg;
    logic          out_end_reg;

    always_ff @(posedge clk)
    begin
        if (adv && d_ctrl_reg.valid && d_ctrl_reg.load_held)
        begin
            held_reg <= pixel;
        end
        if (adv)
        begin
            out_pix_reg <= d_ctrl_reg.src_new ? pixel : held_reg;
            out_end_reg <= d_ctrl_reg.end_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_ctrl_reg.valid && d_ctrl_reg.emit;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_pix_reg[0*SW +: SW];
    assign green_out = out_pix_reg[1*SW +: SW];
    assign blue_out  = out_pix_reg[2*SW +: SW];
    assign frame_end = out_end_reg;

endmodule

>>> hw/rtl/gbd_line_store.sv
module gbd_line_store #(
    parameter int DEPTH = gbd_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(gbd_pkg::MAX_WIDTH_DEF),
    parameter int DW    = gbd_pkg::LINES * gbd_pkg::PIXEL_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write-first: a read of the address being written returns the new entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/gbd_filter.sv
module gbd_filter (
    input  logic                                clk,
    input  logic                                adv,
    input  gbd_pkg::window_t                    window,
    input  logic [gbd_pkg::KSIZE-1:0]           row_mask,
    input  logic [gbd_pkg::KSIZE-1:0]           col_mask,
    input  gbd_pkg::weights_t                   weights,
    output logic [gbd_pkg::PIXEL_W-1:0]         pixel
);

    localparam int NC = gbd_pkg::NCHAN;
    localparam int NG = gbd_pkg::NGROUPS;
    localparam int SW = gbd_pkg::SAMPLE_W;

    logic [NC-1:0][NG-1:0][gbd_pkg::GSUM_W-1:0] gsum_next;
    logic [NC-1:0][NG-1:0][gbd_pkg::GSUM_W-1:0] gsum_reg;
    logic [NC-1:0][NG-1:0][gbd_pkg::PROD_W-1:0] prod_reg;

    // add masked samples that share a weight
    always_comb
    begin
        gsum_next = '0;
        for (int k = 0; k < gbd_pkg::KSIZE; k++)
        begin
            for (int m = 0; m < gbd_pkg::KSIZE; m++)
            begin
                if (row_mask[k] && col_mask[m])
                begin
                    for (int c = 0; c < NC; c++)
                    begin
                        gsum_next[c][gbd_pkg::tap_group(k, m)] =
                            gsum_next[c][gbd_pkg::tap_group(k, m)] +
                            gbd_pkg::GSUM_W'(window[k][m][c*SW +: SW]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gsum_reg <= gsum_next;
            for (int c = 0; c < NC; c++)
            begin
                for (int g = 0; g < NG; g++)
                begin
                    prod_reg[c][g] <= gbd_pkg::PROD_W'(
                        gbd_pkg::PROD_W'(gsum_reg[c][g]) *
                        gbd_pkg::PROD_W'(weights[g]));
                end
            end
        end
    end

    // sum, truncate, saturate
    always_comb
    begin
        logic [gbd_pkg::ACC_W-1:0] acc;
        logic [gbd_pkg::ACC_W-gbd_pkg::FRAC_BITS-1:0] val;
        pixel = '0;
        for (int c = 0; c < NC; c++)
        begin
            acc = '0;
            for (int g = 0; g < NG; g++)
            begin
                acc = acc + gbd_pkg::ACC_W'(prod_reg[c][g]);
            end
            val = acc[gbd_pkg::ACC_W-1:gbd_pkg::FRAC_BITS];
            if (val > (gbd_pkg::ACC_W-gbd_pkg::FRAC_BITS)'(255))
            begin
                pixel[c*SW +: SW] = '1;
            end
            else
            begin
                pixel[c*SW +: SW] = val[SW-1:0];
            end
        end
    end

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH   = gbd_pkg::MAX_WIDTH_DEF;
    localparam int SAMPLE_W    = gbd_pkg::SAMPLE_W;
    localparam int PIXEL_W     = gbd_pkg::PIXEL_W;
    localparam int NCHAN       = gbd_pkg::NCHAN;
    localparam int NGROUPS     = gbd_pkg::NGROUPS;
    localparam int WEIGHT_W    = gbd_pkg::WEIGHT_W;
    localparam int FRAC_BITS   = gbd_pkg::FRAC_BITS;
    localparam int CFG_DATA_W  = gbd_pkg::CFG_DATA_W;
    localparam int CFG_INDEX_W = gbd_pkg::CFG_INDEX_W;
    localparam int IMG_WIDTH_W = gbd_pkg::IMG_WIDTH_W;

    // Ring of the last four rows plus the window, as deep as the widest frame needs
    localparam int RING_SIZE   = 4 * MAX_WIDTH + 5;
    localparam int STALL_LIMIT = 3000;   // cycles with no request or config write taken

    typedef struct {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                last;
    } blur_pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    red_in;
    logic [SAMPLE_W-1:0]    green_in;
    logic [SAMPLE_W-1:0]    blue_in;
    logic                   flush;
    logic                   out_valid;
    logic                   out_stall;
    logic [SAMPLE_W-1:0]    red_out;
    logic [SAMPLE_W-1:0]    green_out;
    logic [SAMPLE_W-1:0]    blue_out;
    logic                   frame_end;

    gaussian_blur_5x5_decimate_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .flush        (flush),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .frame_end    (frame_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the block: registers, frame latch, row ring and counters
    // ------------------------------------------------------------------
    logic [IMG_WIDTH_W-1:0] reg_width;
    bit                     reg_decimate;
    logic [WEIGHT_W-1:0]    reg_weight [NGROUPS];

    logic [PIXEL_W-1:0]     row_ring [RING_SIZE];
    int unsigned            ring_wr;
    int unsigned            col_pos;
    int unsigned            row_pos;
    int unsigned            drain_seen;
    bit                     held_valid;
    logic [PIXEL_W-1:0]     held_pixel;
    longint                 frame_width;
    bit                     frame_decimate;

    blur_pixel_t            expected_pixels [$];

    int  items_sent;
    int  pixels_checked;
    int  frames_sent;
    int  mismatches;

    // Idling knobs: each side draws a wait of 0 to its maximum per request
    int  tx_idle_max;
    int  rx_idle_max;
    int  rx_wait_left;
    int  rx_hold_left;

    function automatic logic [WEIGHT_W-1:0] weight_of(input int d2);
        case (d2)
            0:       return reg_weight[0];
            1:       return reg_weight[1];
            2:       return reg_weight[2];
            4:       return reg_weight[3];
            5:       return reg_weight[4];
            default: return reg_weight[5];
        endcase
    endfunction

    function automatic void latch_frame();
        longint lw;
        lw = longint'(reg_width);
        if (lw == 0)
            lw = 1;
        if (lw > MAX_WIDTH)
            lw = MAX_WIDTH;
        frame_width    = lw;
        frame_decimate = reg_decimate;
    endfunction

    function automatic void reset_mirror();
        reg_width    = IMG_WIDTH_W'(gbd_pkg::RESET_WIDTH);
        reg_decimate = 1'b0;
        reg_weight[0] = gbd_pkg::RESET_W_CENTER;
        reg_weight[1] = gbd_pkg::RESET_W_D1;
        reg_weight[2] = gbd_pkg::RESET_W_D2;
        reg_weight[3] = gbd_pkg::RESET_W_D4;
        reg_weight[4] = gbd_pkg::RESET_W_D5;
        reg_weight[5] = gbd_pkg::RESET_W_D8;
        foreach (row_ring[i])
            row_ring[i] = '0;
        ring_wr    = 0;
        col_pos    = 0;
        row_pos    = 0;
        drain_seen = 0;
        held_valid = 1'b0;
        held_pixel = '0;
        latch_frame();
    endfunction

    // Blur the pixel at frame position p, seen from current position q with f real pixels
    function automatic logic [PIXEL_W-1:0] blur_window(input longint p, input longint q,
                                                       input longint f, input longint w);
        longint      cc;
        longint      col;
        longint      n;
        longint unsigned acc [NCHAN];
        longint unsigned v;
        int unsigned addr;
        logic [PIXEL_W-1:0] pix;
        logic [PIXEL_W-1:0] res;
        cc = p % w;
        res = '0;
        foreach (acc[c])
            acc[c] = 0;
        for (int di = -2; di <= 2; di++)
        begin
            for (int dj = -2; dj <= 2; dj++)
            begin
                col = cc + dj;
                n   = p + di * w + dj;
                if (col < 0 || col >= w || n < 0 || n >= f || n > q)
                    continue;
                addr = (ring_wr + RING_SIZE - int'(q - n)) % RING_SIZE;
                pix  = row_ring[addr];
                for (int c = 0; c < NCHAN; c++)
                    acc[c] += longint'(pix[8*c +: 8]) * weight_of(di * di + dj * dj);
            end
        end
        for (int c = 0; c < NCHAN; c++)
        begin
            v = acc[c] >> FRAC_BITS;
            if (v > 255)
                v = 255;
            res[8*c +: 8] = v[7:0];
        end
        return res;
    endfunction

    function automatic void push_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
        blur_pixel_t e;
        e.red   = pix[7:0];
        e.green = pix[15:8];
        e.blue  = pix[23:16];
        e.last  = last;
        expected_pixels.push_back(e);
    endfunction

    // Advance the mirror by one accepted pixel or flush request
    function automatic void blur_predict(input logic is_flush, input logic [PIXEL_W-1:0] smp);
        bit     fresh;
        bit     produced;
        longint w;
        longint q;
        longint f;
        longint lag;
        longint p;
        longint cr;
        longint cc;
        logic [PIXEL_W-1:0] pix;
        fresh    = (row_pos == 0 && col_pos == 0);
        produced = 1'b0;
        if (is_flush)
        begin
            if (drain_seen == 0 && fresh)
                return;
        end
        else if (drain_seen != 0 || fresh)
        begin
            // a pixel during the drain cuts the old frame short
            if (drain_seen != 0 && held_valid)
            begin
                push_pixel(held_pixel, 1'b1);
                produced = 1'b1;
            end
            held_valid = 1'b0;
            row_pos    = 0;
            col_pos    = 0;
            drain_seen = 0;
            latch_frame();
        end

        w   = frame_width;
        q   = longint'(row_pos) * w + col_pos;
        if (is_flush)
            f = (q >= drain_seen) ? q - drain_seen : 0;
        else
            f = q + 1;
        lag = 2 * w + 2;

        row_ring[ring_wr] = is_flush ? '0 : smp;

        if (q >= lag)
        begin
            p  = q - lag;
            cr = p / w;
            cc = p % w;
            if (frame_decimate)
            begin
                if (cr % 2 == 0 && cc % 2 == 0 && cc + 1 < w && (cr + 1) * w < f)
                begin
                    pix = blur_window(p, q, f, w);
                    if (held_valid && !produced)
                    begin
                        push_pixel(held_pixel, 1'b0);
                        produced = 1'b1;
                    end
                    held_pixel = pix;
                    held_valid = 1'b1;
                end
            end
            else if (!produced)
            begin
                push_pixel(blur_window(p, q, f, w), is_flush && p + 1 == f);
                produced = 1'b1;
            end
        end

        ring_wr = (ring_wr + 1) % RING_SIZE;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 32'hFFFF;
        end
        if (is_flush)
        begin
            drain_seen++;
            if (drain_seen >= lag)
            begin
                if (held_valid && !produced)
                    push_pixel(held_pixel, 1'b1);
                held_valid = 1'b0;
                row_pos    = 0;
                col_pos    = 0;
                drain_seen = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall per request, long hold on demand, checking
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_left--;
        end
        else if (rx_wait_left > 0)
        begin
            out_stall <= 1'b1;
            rx_wait_left--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        blur_pixel_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                       red_out, green_out, blue_out, frame_end);
                mismatches++;
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (red_out !== e.red)
                begin
                    $error("red_out expected %0d got %0d", e.red, red_out);
                    mismatches++;
                end
                if (green_out !== e.green)
                begin
                    $error("green_out expected %0d got %0d", e.green, green_out);
                    mismatches++;
                end
                if (blue_out !== e.blue)
                begin
                    $error("blue_out expected %0d got %0d", e.blue, blue_out);
                    mismatches++;
                end
                if (frame_end !== e.last)
                begin
                    $error("frame_end expected %0b got %0b", e.last, frame_end);
                    mismatches++;
                end
            end
            pixels_checked++;
            rx_wait_left = $urandom_range(0, rx_idle_max);
        end
    end

    // Watchdog: count cycles with no request moved on either side and no register write
    always @(posedge clk)
    begin
        int quiet;
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en))
            quiet = 0;
        else if (rst_n)
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input gbd_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        case (idx)
            gbd_pkg::REG_IMAGE_WIDTH: reg_width     = value[IMG_WIDTH_W-1:0];
            gbd_pkg::REG_DECIMATE:    reg_decimate  = value[0];
            gbd_pkg::REG_W_CENTER:    reg_weight[0] = value;
            gbd_pkg::REG_W_D1:        reg_weight[1] = value;
            gbd_pkg::REG_W_D2:        reg_weight[2] = value;
            gbd_pkg::REG_W_D4:        reg_weight[3] = value;
            gbd_pkg::REG_W_D5:        reg_weight[4] = value;
            gbd_pkg::REG_W_D8:        reg_weight[5] = value;
            default:                  ;
        endcase
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_weights(input logic [WEIGHT_W-1:0] wc, input logic [WEIGHT_W-1:0] w1,
                               input logic [WEIGHT_W-1:0] w2, input logic [WEIGHT_W-1:0] w4,
                               input logic [WEIGHT_W-1:0] w5, input logic [WEIGHT_W-1:0] w8);
        write_reg(gbd_pkg::REG_W_CENTER, wc);
        write_reg(gbd_pkg::REG_W_D1, w1);
        write_reg(gbd_pkg::REG_W_D2, w2);
        write_reg(gbd_pkg::REG_W_D4, w4);
        write_reg(gbd_pkg::REG_W_D5, w5);
        write_reg(gbd_pkg::REG_W_D8, w8);
    endtask

    // Offer one request; return at the edge that accepts it, valid left high
    task automatic send_item(input logic is_flush, input logic [PIXEL_W-1:0] smp);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        red_in   <= smp[7:0];
        green_in <= smp[15:8];
        blue_in  <= smp[23:16];
        flush    <= is_flush;
        do
            @(posedge clk);
        while (in_stall);
        blur_predict(is_flush, smp);
        items_sent++;
    endtask

    task automatic send_frame(input int npix, input int nflush);
        for (int i = 0; i < npix; i++)
            send_item(1'b0, PIXEL_W'($urandom));
        for (int i = 0; i < nflush; i++)
            send_item(1'b1, PIXEL_W'($urandom));
        frames_sent++;
    endtask

    function automatic int drain_len();
        longint lw;
        lw = longint'(reg_width);
        if (lw == 0)
            lw = 1;
        if (lw > MAX_WIDTH)
            lw = MAX_WIDTH;
        return int'(2 * lw + 2);
    endfunction

    // Drop valid, wait for every result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset weights and mode on a narrow frame, full drain
    task automatic test_reset_config();
        write_reg(gbd_pkg::REG_IMAGE_WIDTH, 16'd6);
        send_frame(10, drain_len());
        wait_idle();
    endtask

    // Extreme samples and weights, stray flush outside a frame
    task automatic test_extremes();
        logic [PIXEL_W-1:0] pat [8];
        pat = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hFF00FF,
                24'h00FF00, 24'hFFFF00, 24'h800001, 24'h7F80FE};
        write_reg(gbd_pkg::REG_IMAGE_WIDTH, 16'd4);
        write_reg(gbd_pkg::REG_DECIMATE, 16'd0);
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // flush with no frame open is ignored
        send_item(1'b1, 24'hFFFFFF);
        send_item(1'b1, 24'h000000);
        foreach (pat[i])
            send_item(1'b0, pat[i]);
        for (int i = 0; i < drain_len(); i++)
            send_item(1'b1, 24'h0);
        wait_idle();
        set_weights(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_frame(6, drain_len());
        wait_idle();
        set_weights(16'h8000, 16'h1000, 16'h0800, 16'h0400, 16'h0200, 16'h0001);
        send_frame(7, drain_len());   // partial last row
        wait_idle();
        frames_sent++;
    endtask

    // Width zero taken as one, width one in decimate and in normal mode
    task automatic test_width_limits();
        write_reg(gbd_pkg::REG_IMAGE_WIDTH, 16'd0);
        write_reg(gbd_pkg::REG_DECIMATE, 16'd1);
        send_frame(5, drain_len());
        wait_idle();
        write_reg(gbd_pkg::REG_DECIMATE, 16'd0);
        send_frame(5, drain_len());
        wait_idle();
    endtask

    // Pixel arriving mid-drain ends the frame early and opens the next one
    task automatic test_drain_cut();
        write_reg(gbd_pkg::REG_IMAGE_WIDTH, 16'd5);
        write_reg(gbd_pkg::REG_DECIMATE, 16'd1);
        set_weights(16'd12000, 16'd9000, 16'd6000, 16'd4000, 16'd3000, 16'd2000);
        send_frame(17, 3);
        send_frame(8, drain_len());
        wait_idle();
        write_reg(gbd_pkg::REG_DECIMATE, 16'd0);
        send_frame(12, 4);
        send_frame(9, drain_len());
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps going; then the sender pauses
    task automatic test_backpressure();
        write_reg(gbd_pkg::REG_IMAGE_WIDTH, 16'd8);
        write_reg(gbd_pkg::REG_DECIMATE, 16'd0);
        tx_idle_max = 0;
        send_item(1'b0, PIXEL_W'($urandom));
        rx_hold_left = 300;
        send_frame(47, 0);
        tx_idle_max = 10;
        wait_idle();
        for (int i = 0; i < drain_len(); i++)
            send_item(1'b1, 24'h0);
        wait_idle();
    endtask

    // Random frames: random sizes, modes and weights; some cut short mid-drain
    task automatic test_random_frames();
        int  start;
        int  npix;
        int  nflush;
        bit  cut;
        start = items_sent;
        cut   = 1'b0;
        while (items_sent - start < 650)
        begin
            if (!cut)
            begin
                wait_idle();
                write_reg(gbd_pkg::REG_IMAGE_WIDTH,
                          CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                      $urandom_range(11, 40) : $urandom_range(1, 10)));
                write_reg(gbd_pkg::REG_DECIMATE, CFG_DATA_W'($urandom_range(0, 1)));
                case ($urandom_range(0, 3))
                    0: set_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                   WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                   WEIGHT_W'($urandom), WEIGHT_W'($urandom));
                    1: set_weights(gbd_pkg::RESET_W_CENTER, gbd_pkg::RESET_W_D1,
                                   gbd_pkg::RESET_W_D2, gbd_pkg::RESET_W_D4,
                                   gbd_pkg::RESET_W_D5, gbd_pkg::RESET_W_D8);
                    default: set_weights(WEIGHT_W'($urandom_range(0, 16000)),
                                         WEIGHT_W'($urandom_range(0, 8000)),
                                         WEIGHT_W'($urandom_range(0, 6000)),
                                         WEIGHT_W'($urandom_range(0, 4000)),
                                         WEIGHT_W'($urandom_range(0, 3000)),
                                         WEIGHT_W'($urandom_range(0, 2000)));
                endcase
                tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
                rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            end
            npix = $urandom_range(1, 6 * ((drain_len() - 2) / 2));
            cut  = ($urandom_range(0, 4) == 0);
            nflush = cut ? $urandom_range(1, drain_len() - 1) : drain_len();
            send_frame(npix, nflush);
        end
        if (cut)
            send_frame(1, drain_len());
        wait_idle();
        tx_idle_max = 10;
        rx_idle_max = 10;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        red_in       = '0;
        green_in     = '0;
        blue_in      = '0;
        flush        = 1'b0;
        out_stall    = 1'b0;
        tx_idle_max  = 10;
        rx_idle_max  = 10;
        rx_wait_left = 0;
        rx_hold_left = 0;
        items_sent   = 0;
        pixels_checked = 0;
        frames_sent  = 0;
        mismatches   = 0;
        reset_mirror();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_config();
        test_extremes();
        test_width_limits();
        test_drain_cut();
        test_backpressure();
        test_random_frames();

        wait_idle();
        $display("covered %0d requests in %0d frames, %0d results checked", items_sent,
                 frames_sent, pixels_checked);
        $display("widths 0 to 40, both modes, stray and cut drains, saturation, long stalls");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
